@@ rtl/aligned_implicit_list_allocator_unit_macros.svh @@
// assertion helpers shared by the checker
`ifndef ALIGNED_IMPLICIT_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define ALIGNED_IMPLICIT_LIST_ALLOCATOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ALIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ALIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/alia_pkg.sv @@
`timescale 1ns / 1ps
package alia_pkg;

  localparam int ALIA_POOL_WORDS = 1024;
  localparam int ALIA_WORD_BYTES = 8;

  // result codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ZERO_SIZE   = 3'd1,
    ST_BAD_ALIGN   = 3'd2,
    ST_NO_SPACE    = 3'd3,
    ST_BAD_FREE    = 3'd4
  } status_t;

  // what the current header walk is for
  typedef enum logic [1:0] {
    WK_HINT,
    WK_WALK,
    WK_FREE,
    WK_MALL
  } walk_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ALGN,
    S_CHK,
    S_HINT,
    S_RD,
    S_HDR,
    S_DIVH,
    S_MUL,
    S_CMP,
    S_TK1,
    S_TK2,
    S_TK3,
    S_TKRD,
    S_TKHDR,
    S_MFRD,
    S_MFHDR,
    S_MFWR,
    S_RESP
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_step;
    logic    load_in;
    logic    div_h;
    logic    set_aw;
    logic    set_need;
    logic    cur_hint;
    logic    cur_zero;
    logic    rd_cur;
    logic    ld_sz;
    logic    cur_adv;
    logic    cur_adv_acc;
    logic    set_h;
    logic    wr_tail;
    logic    wr_lead;
    logic    wr_mid;
    logic    rd_end;
    logic    hint_take;
    logic    mf_rd;
    logic    mf_acc;
    logic    mf_wr;
    logic    out_load;
    status_t out_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic align_bad;
    logic req_zero;
    logic hint_valid;
    logic cur_oob;
    logic rd_idle;
    logic rd_zero;
    logic fit;
    logic free_match;
    logic nxt_oob;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/aligned_implicit_list_allocator_unit.sv @@
`timescale 1ns / 1ps
// First-fit allocator over an implicit list of one-word chunk headers. Each request
// (allocate or free) gives exactly one result. After reset the header memory is
// cleared one entry a cycle, all POOL_WORDS entries, with s_tready low. The word size
// must be a power of two. A free walks the chunk list, then merges the idle neighbours
// after the freed chunk. An allocate checks the alignment and the size, then walks the
// headers; each idle chunk tried waits on the bit-serial alignment divider, 16 bits
// wide at the default pool size, to round its data start up. A fit is split by writing
// the tail, lead and middle headers. A failed search merges the whole pool and walks
// again. The header memory's single read port, one header a cycle, bounds every walk.
module aligned_implicit_list_allocator_unit import alia_pkg::*; #(
  parameter int POOL_WORDS = ALIA_POOL_WORDS,
  parameter int WORD_BYTES = ALIA_WORD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // request_bytes[13:0], align_bytes[27:14], free_addr[40:28]
  input  logic        s_tuser,  // mode: 0 allocate, 1 free
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // status[2:0], data_addr[15:3], high_water[29:16]
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  alia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // header memory, divider and result register
  alia_datapath #(
    .POOL_WORDS (POOL_WORDS),
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (s_tuser),
    .in_request_bytes (s_tdata[13:0]),
    .in_align_bytes   (s_tdata[27:14]),
    .in_free_addr     (s_tdata[40:28]),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .out_data         (m_tdata)
  );

endmodule

@@ rtl/alia_div.sv @@
`timescale 1ns / 1ps
module alia_div #(
  parameter int NW = 16,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          done
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW-1:0]   dvs;
  logic [DW:0]     trial;
  logic            ge;

  // restoring step: one quotient bit a cycle
  assign trial = {rem, quo[NW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
    end
  end

endmodule

@@ rtl/alia_datapath.sv @@
`timescale 1ns / 1ps
module alia_datapath import alia_pkg::*; #(
  parameter int POOL_WORDS = ALIA_POOL_WORDS,
  parameter int WORD_BYTES = ALIA_WORD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        in_mode,
  input  logic [13:0] in_request_bytes,
  input  logic [13:0] in_align_bytes,
  input  logic [12:0] in_free_addr,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_data
);

  localparam int AW  = $clog2(POOL_WORDS);
  localparam int SZW = $clog2(POOL_WORDS + 1);
  localparam int HDW = SZW + 1;
  localparam int CW  = ((SZW > 14) ? SZW : 14) + 2;
  localparam int MW  = CW + 5;
  // word size is a power of two: byte to word conversion is a shift
  localparam int WBS = $clog2(WORD_BYTES);
  localparam logic [CW-1:0]  PW_C = CW'(POOL_WORDS);
  localparam logic [MW-1:0]  WB_M = MW'(WORD_BYTES);

  // header store: {occupied, size in words}
  logic [HDW-1:0] mem [POOL_WORDS];
  logic [HDW-1:0] rd_q;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [HDW-1:0] wdata;

  logic [SZW-1:0] clr_cnt;
  logic           mode_q;
  logic [13:0]    req_q, align_q, aw;
  logic [12:0]    faddr_q, need, addr_q;
  logic           align_bad;
  logic [CW-1:0]  cur, h;
  logic [SZW-1:0] csz;
  logic [AW-1:0]  hint;
  logic           hint_valid, end_in;
  logic [MW-1:0]  hw;

  logic [CW-1:0]  div_q;
  logic [13:0]    div_r;
  logic           div_done, div_start;
  logic [CW-1:0]  div_num;
  logic [13:0]    div_den;

  logic [SZW-1:0]   rd_size;
  logic             rd_idle, rd_zero;
  logic [CW-1:0]    cur_sum, end_w, ceil_q;
  logic [CW+13:0]   hprod;
  logic [MW-1:0]    data_cur, end_bytes, addr_full;

  assign rd_size   = rd_q[SZW-1:0];
  assign rd_idle   = !rd_q[SZW];
  assign rd_zero   = (rd_size == '0);
  assign cur_sum   = cur + CW'(csz);
  assign end_w     = h + CW'(need);
  assign ceil_q    = div_q + CW'(div_r != '0);
  assign hprod     = (CW+14)'(ceil_q) * (CW+14)'(aw);
  assign data_cur  = (MW'(cur) + MW'(1)) * WB_M;
  assign end_bytes = MW'(end_w) * WB_M;
  assign addr_full = (MW'(h) + MW'(1)) * WB_M;

  // status towards the controller
  always_comb begin
    sts.clr_done   = (clr_cnt == SZW'(POOL_WORDS));
    sts.div_done   = div_done;
    sts.align_bad  = align_bad;
    sts.req_zero   = (req_q == '0);
    sts.hint_valid = hint_valid;
    sts.cur_oob    = (cur >= PW_C);
    sts.rd_idle    = rd_idle;
    sts.rd_zero    = rd_zero;
    sts.fit        = (end_w <= cur_sum);
    sts.free_match = (data_cur == MW'(faddr_q)) && !rd_idle;
    sts.nxt_oob    = (cur_sum >= PW_C);
    sts.out_free   = !out_valid || out_ready;
  end

  // divider rounds the data start up to the alignment in words
  assign div_start = cmd.div_h;
  assign div_num   = cur + CW'(1);
  assign div_den   = aw;

  alia_div #(
    .NW (CW),
    .DW (14)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .rem   (div_r),
    .done  (div_done)
  );

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = cur[AW-1:0];
    wdata = {1'b0, csz};
    priority if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt[AW-1:0];
      wdata = (clr_cnt == '0) ? {1'b0, SZW'(POOL_WORDS)} : '0;
    end else if (cmd.wr_tail) begin
      we    = end_w < cur_sum;
      waddr = end_w[AW-1:0];
      wdata = {1'b0, SZW'(cur_sum - end_w)};
    end else if (cmd.wr_lead) begin
      we    = h != cur;
      waddr = cur[AW-1:0];
      wdata = {1'b0, SZW'(h - cur)};
    end else if (cmd.wr_mid) begin
      we    = 1'b1;
      waddr = h[AW-1:0];
      wdata = {1'b1, SZW'(need)};
    end else if (cmd.mf_wr) begin
      we    = 1'b1;
    end
  end

  // read port select
  always_comb begin
    re    = 1'b0;
    raddr = cur[AW-1:0];
    priority if (cmd.rd_cur) begin
      re = 1'b1;
    end else if (cmd.mf_rd) begin
      re    = 1'b1;
      raddr = cur_sum[AW-1:0];
    end else if (cmd.rd_end) begin
      re    = end_w < PW_C;
      raddr = end_w[AW-1:0];
    end
  end

  // header memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // control state: clear counter, hint, high water, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      hint       <= '0;
      hint_valid <= 1'b1;
      hw         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.wr_mid && end_bytes > hw) begin
        hw <= end_bytes;
      end
      if (cmd.hint_take) begin
        hint_valid <= end_in && rd_idle && !rd_zero;
        hint       <= end_w[AW-1:0];
      end else if (cmd.mf_wr) begin
        hint_valid <= 1'b1;
        hint       <= cur[AW-1:0];
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q  <= in_mode;
      req_q   <= in_request_bytes;
      align_q <= in_align_bytes;
      faddr_q <= in_free_addr;
    end
    if (cmd.set_aw) begin
      aw        <= align_q >> WBS;
      align_bad <= (align_q == '0) || (align_q[WBS-1:0] != '0);
    end
    if (cmd.set_need) begin
      need <= 13'(req_q >> WBS) + 13'(req_q[WBS-1:0] != '0) + 13'd1;
    end
    if (cmd.cur_hint) begin
      cur <= CW'(hint);
    end else if (cmd.cur_zero) begin
      cur <= '0;
    end else if (cmd.cur_adv) begin
      cur <= cur + CW'(rd_size);
    end else if (cmd.cur_adv_acc) begin
      cur <= cur_sum;
    end
    if (cmd.ld_sz) begin
      csz <= rd_size;
    end else if (cmd.mf_acc) begin
      csz <= csz + rd_size;
    end
    if (cmd.set_h) begin
      h <= hprod[CW-1:0] - CW'(1);
    end
    if (cmd.wr_mid) begin
      addr_q <= addr_full[12:0];
    end
    if (cmd.rd_end) begin
      end_in <= end_w < PW_C;
    end
    if (cmd.out_load) begin
      out_data <= {2'b00, hw[13:0],
                   ((cmd.out_code == ST_OK) && !mode_q) ? addr_q : 13'd0,
                   cmd.out_code};
    end
  end

endmodule

@@ rtl/alia_ctrl.sv @@
`timescale 1ns / 1ps
module alia_ctrl import alia_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state, state_next;
  walk_t      walk, walk_next;
  logic       pass, pass_next;
  status_t    code, code_next;
  logic       cand;

  // idle chunk with a nonzero size
  assign cand = sts.rd_idle && !sts.rd_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      walk  <= WK_HINT;
      pass  <= 1'b0;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      walk  <= walk_next;
      pass  <= pass_next;
      code  <= code_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    walk_next  = walk;
    pass_next  = pass;
    code_next  = code;
    unique case (state)
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            walk_next  = WK_FREE;
            state_next = S_RD;
          end else begin
            state_next = S_ALGN;
          end
        end
      end
      S_ALGN: state_next = S_CHK;
      S_CHK: begin
        if (sts.align_bad) begin
          code_next  = ST_BAD_ALIGN;
          state_next = S_RESP;
        end else if (sts.req_zero) begin
          code_next  = ST_ZERO_SIZE;
          state_next = S_RESP;
        end else begin
          pass_next  = 1'b0;
          state_next = S_HINT;
        end
      end
      S_HINT: begin
        walk_next  = sts.hint_valid ? WK_HINT : WK_WALK;
        state_next = S_RD;
      end
      S_RD: begin
        if (!sts.cur_oob) begin
          state_next = S_HDR;
        end else begin
          unique case (walk)
            WK_FREE: begin
              code_next  = ST_BAD_FREE;
              state_next = S_RESP;
            end
            WK_MALL: begin
              pass_next  = 1'b1;
              state_next = S_HINT;
            end
            WK_HINT, WK_WALK: begin
              if (pass) begin
                code_next  = ST_NO_SPACE;
                state_next = S_RESP;
              end else begin
                walk_next  = WK_MALL;
                state_next = S_RD;
              end
            end
          endcase
        end
      end
      S_HDR: begin
        unique case (walk)
          WK_HINT: begin
            if (cand) begin
              state_next = S_DIVH;
            end else begin
              walk_next  = WK_WALK;
              state_next = S_RD;
            end
          end
          WK_WALK: begin
            if (cand) begin
              state_next = S_DIVH;
            end else if (sts.rd_zero) begin
              if (pass) begin
                code_next  = ST_NO_SPACE;
                state_next = S_RESP;
              end else begin
                walk_next  = WK_MALL;
                state_next = S_RD;
              end
            end else begin
              state_next = S_RD;
            end
          end
          WK_FREE: begin
            if (sts.free_match) begin
              state_next = S_MFRD;
            end else if (sts.rd_zero) begin
              code_next  = ST_BAD_FREE;
              state_next = S_RESP;
            end else begin
              state_next = S_RD;
            end
          end
          WK_MALL: begin
            if (cand) begin
              state_next = S_MFRD;
            end else if (sts.rd_zero) begin
              pass_next  = 1'b1;
              state_next = S_HINT;
            end else begin
              state_next = S_RD;
            end
          end
        endcase
      end
      S_DIVH: if (sts.div_done) state_next = S_MUL;
      S_MUL: state_next = S_CMP;
      S_CMP: begin
        if (sts.fit) begin
          state_next = S_TK1;
        end else begin
          walk_next  = WK_WALK;
          state_next = S_RD;
        end
      end
      S_TK1: state_next = S_TK2;
      S_TK2: state_next = S_TK3;
      S_TK3: state_next = S_TKRD;
      S_TKRD: state_next = S_TKHDR;
      S_TKHDR: begin
        code_next  = ST_OK;
        state_next = S_RESP;
      end
      S_MFRD: state_next = sts.nxt_oob ? S_MFWR : S_MFHDR;
      S_MFHDR: state_next = cand ? S_MFRD : S_MFWR;
      S_MFWR: begin
        if (walk == WK_FREE) begin
          code_next  = ST_OK;
          state_next = S_RESP;
        end else begin
          state_next = S_RD;
        end
      end
      S_RESP: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.out_code = code;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clr_step = !sts.clr_done;
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_in  = in_valid;
        cmd.cur_zero = in_valid;
      end
      S_ALGN: cmd.set_aw = 1'b1;
      S_CHK: cmd.set_need = !sts.align_bad && !sts.req_zero;
      S_HINT: begin
        cmd.cur_hint = sts.hint_valid;
        cmd.cur_zero = !sts.hint_valid;
      end
      S_RD: begin
        cmd.rd_cur   = !sts.cur_oob;
        cmd.cur_zero = sts.cur_oob && !pass &&
                       ((walk == WK_HINT) || (walk == WK_WALK));
      end
      S_HDR: begin
        cmd.ld_sz = 1'b1;
        unique case (walk)
          WK_HINT: begin
            cmd.div_h    = cand;
            cmd.cur_zero = !cand;
          end
          WK_WALK: begin
            cmd.div_h    = cand;
            cmd.cur_adv  = !cand && !sts.rd_zero;
            cmd.cur_zero = !cand && sts.rd_zero && !pass;
          end
          WK_FREE: cmd.cur_adv = !sts.free_match && !sts.rd_zero;
          WK_MALL: cmd.cur_adv = !cand && !sts.rd_zero;
        endcase
      end
      S_DIVH: ;
      S_MUL: cmd.set_h = 1'b1;
      S_CMP: begin
        cmd.cur_zero = !sts.fit && (walk == WK_HINT);
        cmd.cur_adv  = !sts.fit && (walk == WK_WALK);
      end
      S_TK1: cmd.wr_tail = 1'b1;
      S_TK2: cmd.wr_lead = 1'b1;
      S_TK3: cmd.wr_mid = 1'b1;
      S_TKRD: cmd.rd_end = 1'b1;
      S_TKHDR: cmd.hint_take = 1'b1;
      S_MFRD: cmd.mf_rd = !sts.nxt_oob;
      S_MFHDR: cmd.mf_acc = cand;
      S_MFWR: begin
        cmd.mf_wr       = 1'b1;
        cmd.cur_adv_acc = (walk == WK_MALL);
      end
      S_RESP: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/alia_checker.sv @@
`timescale 1ns / 1ps
`include "aligned_implicit_list_allocator_unit_macros.svh"
module alia_checker import alia_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result holds
  `ALIA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")

  // status code in range
  `ALIA_ASSERT_NOW(a_status_range, clk, rst, m_tvalid, m_tdata[2:0] <= ST_BAD_FREE, "status out of range")

  // address only reported on success
  `ALIA_ASSERT_NOW(a_addr_zero, clk, rst, m_tvalid && (m_tdata[2:0] != ST_OK), m_tdata[15:3] == 13'd0, "address set on failed request")

  // no request taken at the start of the header memory clear after reset
  `ALIA_ASSERT_NOW(a_clear_after_reset, clk, rst, $past(rst), !s_tready, "request taken during clear")

endmodule

bind aligned_implicit_list_allocator_unit alia_checker u_alia_checker (.*);
